>>> src/bdeq_pkg.sv
`default_nettype none

package bdeq_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 11;
    localparam int DEPTH_DEF = 1024;
    localparam int CAP_RESET = 1024;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK       = 3'd4
    } action_t;

    // what every cell of a chain does at each clock edge
    typedef enum logic [1:0] {
        CH_HOLD,
        CH_SHIFT_IN,   // take the lower neighbor's value (cell 0 takes new data)
        CH_SHIFT_OUT,  // take the upper neighbor's value
        CH_APPEND      // the cell at position count takes new data
    } chain_op_t;

    typedef struct packed {
        action_t                  action;
        logic signed [DATA_W-1:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } res_t;

endpackage

`default_nettype wire

>>> src/bounded_double_ended_queue_top.sv
`default_nettype none

// Bounded double-ended queue of 32-bit signed values. Each cmd transfer
// carries one action (push front, push back, pop front, pop back, peek) and
// produces exactly one res transfer: ok, the front and rear values after the
// action (-1 when empty), and empty/full flags. A push fails when the count
// has reached the limit, min(capacity, DEPTH); a pop fails on an empty queue;
// failed or unknown actions leave the contents alone (unknown ones report ok
// 0, peek reports ok 1). Storage is two rows of DEPTH cells: one row keeps
// the entries in order from the front, the other in order from the rear, so
// both ends sit in cell 0 of a row and every action is one shift or one
// indexed write per row. An item is taken in one cycle and its result is
// offered on the next; one item per cycle is sustained as long as res_ready
// stays high. Capacity (register 0, byte address 0, 11 bits, reset 1024)
// is written over the APB port; the user must write it only while the queue
// has no result pending, which the block itself does not enforce. A value
// above DEPTH acts as DEPTH, zero blocks all pushes. Entry contents need no
// clearing after reset: only occupied cells are ever shown.

module bounded_double_ended_queue_top #(
    parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                cmd_valid,
    output logic                               cmd_ready,
    input  bdeq_pkg::cmd_t                     cmd,

    output logic                               res_valid,
    input  wire                                res_ready,
    output bdeq_pkg::res_t                     res,

    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [bdeq_pkg::PADDR_W-1:0]       paddr,
    input  wire  [bdeq_pkg::PDATA_W-1:0]       pwdata,
    output logic [bdeq_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import bdeq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    // common width for comparing count, capacity and DEPTH
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // ---------------- configuration ----------------
    logic [CAP_W-1:0] cap_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata = PDATA_W'(cap_reg);
        end
    end

    // ---------------- occupancy ----------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LIM_W-1:0] cap_ext;
    logic [LIM_W-1:0] depth_ext;
    logic [LIM_W-1:0] limit;
    logic             full;
    logic             empty;

    assign cap_ext   = LIM_W'(cap_reg);
    assign depth_ext = LIM_W'(DEPTH);
    assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign full      = LIM_W'(count_reg) >= limit;
    assign empty     = (count_reg == '0);

    // ---------------- action decode ----------------
    logic      cmd_fire;
    logic      ok_next;
    chain_op_t fwd_op;   // row ordered from the front
    chain_op_t bwd_op;   // row ordered from the rear

    assign cmd_ready = !res_valid || res_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;

    always_comb
    begin
        ok_next    = 1'b0;
        count_next = count_reg;
        fwd_op     = CH_HOLD;
        bwd_op     = CH_HOLD;
        case (cmd.action)
            ACT_PUSH_FRONT:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                    fwd_op     = CH_SHIFT_IN;
                    bwd_op     = CH_APPEND;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                    fwd_op     = CH_APPEND;
                    bwd_op     = CH_SHIFT_IN;
                end
            end
            ACT_POP_FRONT:
            begin
                if (!empty)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                    fwd_op     = CH_SHIFT_OUT;
                end
            end
            ACT_POP_BACK:
            begin
                if (!empty)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                    bwd_op     = CH_SHIFT_OUT;
                end
            end
            ACT_PEEK:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
        if (!cmd_fire)
        begin
            fwd_op     = CH_HOLD;
            bwd_op     = CH_HOLD;
            count_next = count_reg;
        end
    end

    // ---------------- cell rows ----------------
    logic [DATA_W-1:0] front_head;
    logic [DATA_W-1:0] rear_head;

    bdeq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_fwd (
        .clk   (clk),
        .op    (fwd_op),
        .count (count_reg),
        .data  (cmd.data_in),
        .head  (front_head)
    );

    bdeq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_bwd (
        .clk   (clk),
        .op    (bwd_op),
        .count (count_reg),
        .data  (cmd.data_in),
        .head  (rear_head)
    );

    // ---------------- result ----------------
    // The state registers already hold the post-action queue while the
    // result waits, and no new item enters before the result is taken,
    // so front/rear/flags are read straight from the state.
    logic res_valid_reg;
    logic ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd_fire)
            begin
                res_valid_reg <= 1'b1;
                ok_reg        <= ok_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid       = res_valid_reg;
    assign res.ok          = ok_reg;
    assign res.front_value = empty ? '1 : front_head;
    assign res.rear_value  = empty ? '1 : rear_head;
    assign res.is_empty    = empty;
    assign res.is_full     = full;

endmodule

`default_nettype wire

>>> src/bdeq_cell.sv
`default_nettype none

module bdeq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 11
) (
    input  wire                              clk,
    input  bdeq_pkg::chain_op_t              op,
    input  wire  [CNT_W-1:0]                 count,
    input  wire  [bdeq_pkg::DATA_W-1:0]      data,
    input  wire  [bdeq_pkg::DATA_W-1:0]      lower,
    input  wire  [bdeq_pkg::DATA_W-1:0]      upper,
    output logic [bdeq_pkg::DATA_W-1:0]      q
);
    import bdeq_pkg::*;

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (op)
            CH_SHIFT_IN:  q_next = lower;
            CH_SHIFT_OUT: q_next = upper;
            CH_APPEND:
            begin
                if (count == CNT_W'(IDX))
                begin
                    q_next = data;
                end
            end
            default:      q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

>>> src/bdeq_chain.sv
`default_nettype none

module bdeq_chain #(
    parameter int DEPTH = bdeq_pkg::DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                              clk,
    input  bdeq_pkg::chain_op_t              op,
    input  wire  [CNT_W-1:0]                 count,
    input  wire  [bdeq_pkg::DATA_W-1:0]      data,
    output logic [bdeq_pkg::DATA_W-1:0]      head
);
    import bdeq_pkg::*;

    logic [DATA_W-1:0] q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = data;
        end
        else
        begin : g_mid_lo
            assign lower = q[i-1];
        end

        // last cell has nothing above it; a shift-out leaves it stale,
        // which is past the occupied range anyway
        if (i == DEPTH - 1)
        begin : g_last
            assign upper = q[i];
        end
        else
        begin : g_mid_hi
            assign upper = q[i+1];
        end

        bdeq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .count (count),
            .data  (data),
            .lower (lower),
            .upper (upper),
            .q     (q[i])
        );
    end

    assign head = q[0];

endmodule

`default_nettype wire
